### src/xsr_pkg.sv
// xsr_pkg: types, constants and the control-store program of the xoshiro256** core.
// Used by the channel interfaces, the sequencer and the top level; no dependencies.
package xsr_pkg;

  localparam int WORD_W       = 64;
  localparam int RUN_W        = 63;
  localparam int MANT_W       = 53;
  localparam int WARMUP_STEPS = 8;
  localparam int SEED_WORDS   = 4;
  localparam int CNT_W        = $clog2(SEED_WORDS + 1);
  localparam int WARM_W       = (WARMUP_STEPS < 1) ? 1 : $clog2(WARMUP_STEPS + 1);
  localparam int PC_W         = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [RUN_W-1:0]  run_t;
  typedef logic [MANT_W-1:0] mant_t;

  localparam word_t GOLDEN_INC    = 64'h9E37_79B9_7F4A_7C15;
  localparam word_t MIX_MUL_A     = 64'hBF58_476D_1CE4_E5B9;
  localparam word_t MIX_MUL_B     = 64'h94D0_49BB_1331_11EB;
  localparam word_t BASE_SEED_RST = 64'd12345;

  localparam logic REQ_RESEED = 1'b0;
  localparam logic REQ_DRAW   = 1'b1;

  // z register operations
  localparam logic [2:0] Z_NONE   = 3'd0;
  localparam logic [2:0] Z_RUN1   = 3'd1;  // run index + 1
  localparam logic [2:0] Z_CTRINC = 3'd2;  // counter + golden increment
  localparam logic [2:0] Z_XS30   = 3'd3;  // z ^ (z >> 30)
  localparam logic [2:0] Z_ACC27  = 3'd4;  // acc ^ (acc >> 27)
  localparam logic [2:0] Z_ACC31  = 3'd5;  // acc ^ (acc >> 31)
  localparam logic [2:0] Z_S1X5   = 3'd6;  // s1 * 5

  // multiplier operand halves: z half x constant half
  localparam logic [1:0] MUL_LL = 2'd0;
  localparam logic [1:0] MUL_LH = 2'd1;
  localparam logic [1:0] MUL_HL = 2'd2;

  localparam logic [1:0] K_GOLD = 2'd0;
  localparam logic [1:0] K_MIXA = 2'd1;
  localparam logic [1:0] K_MIXB = 2'd2;

  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADDH = 2'd2;  // acc += prod << 32

  localparam logic [1:0] C_NONE = 2'd0;
  localparam logic [1:0] C_BASE = 2'd1;  // acc + base seed
  localparam logic [1:0] C_INC  = 2'd2;
  localparam logic [1:0] C_Z    = 2'd3;

  localparam logic [1:0] JC_NONE = 2'd0;
  localparam logic [1:0] JC_MIX  = 2'd1;  // loop while seed words remain
  localparam logic [1:0] JC_WARM = 2'd2;  // repeat until warmup count reached

  localparam logic [PC_W-1:0] A_RESEED = 5'd0;
  localparam logic [PC_W-1:0] A_MIX    = 5'd6;
  localparam logic [PC_W-1:0] A_WARM   = 5'd19;
  localparam logic [PC_W-1:0] A_DRAW   = 5'd20;

  // datapath enables, after gating by the sequencer
  typedef struct packed {
    logic [2:0] z_op;
    logic [1:0] mul_op;
    logic [1:0] k_sel;
    logic [1:0] acc_op;
    logic [1:0] ctr_op;
    logic       shift_s;
    logic       adv;
    logic       emit;
  } xsr_ctl_t;

  // one microword
  typedef struct packed {
    xsr_ctl_t        body;
    logic            store;
    logic [1:0]      jc;
    logic [PC_W-1:0] jaddr;
    logic            fin;
  } xsr_uw_t;

  function automatic xsr_uw_t uw_rom(input logic [PC_W-1:0] addr);
    xsr_uw_t uw;
    uw = '0;
    case (addr)
      5'd0:  uw.body.z_op = Z_RUN1;
      5'd1:  begin
        uw.body.mul_op = MUL_LL; uw.body.k_sel = K_GOLD;
      end
      5'd2:  begin
        uw.body.acc_op = ACC_LOAD; uw.body.mul_op = MUL_LH; uw.body.k_sel = K_GOLD;
      end
      5'd3:  begin
        uw.body.acc_op = ACC_ADDH; uw.body.mul_op = MUL_HL; uw.body.k_sel = K_GOLD;
      end
      5'd4:  uw.body.acc_op = ACC_ADDH;
      5'd5:  uw.body.ctr_op = C_BASE;
      5'd6:  begin
        uw.body.z_op = Z_CTRINC; uw.body.ctr_op = C_INC;
      end
      5'd7:  uw.body.z_op = Z_XS30;
      5'd8:  begin
        uw.body.mul_op = MUL_LL; uw.body.k_sel = K_MIXA;
      end
      5'd9:  begin
        uw.body.acc_op = ACC_LOAD; uw.body.mul_op = MUL_LH; uw.body.k_sel = K_MIXA;
      end
      5'd10: begin
        uw.body.acc_op = ACC_ADDH; uw.body.mul_op = MUL_HL; uw.body.k_sel = K_MIXA;
      end
      5'd11: uw.body.acc_op = ACC_ADDH;
      5'd12: uw.body.z_op = Z_ACC27;
      5'd13: begin
        uw.body.mul_op = MUL_LL; uw.body.k_sel = K_MIXB;
      end
      5'd14: begin
        uw.body.acc_op = ACC_LOAD; uw.body.mul_op = MUL_LH; uw.body.k_sel = K_MIXB;
      end
      5'd15: begin
        uw.body.acc_op = ACC_ADDH; uw.body.mul_op = MUL_HL; uw.body.k_sel = K_MIXB;
      end
      5'd16: uw.body.acc_op = ACC_ADDH;
      5'd17: uw.body.z_op = Z_ACC31;
      5'd18: begin
        uw.store = 1'b1; uw.jc = JC_MIX; uw.jaddr = A_MIX;
      end
      5'd19: begin
        uw.body.adv = 1'b1; uw.jc = JC_WARM; uw.jaddr = A_WARM;
      end
      5'd20: uw.body.z_op = Z_S1X5;
      5'd21: begin
        uw.body.emit = 1'b1; uw.body.adv = 1'b1; uw.fin = 1'b1;
      end
      default: uw.fin = 1'b1;
    endcase
    return uw;
  endfunction

endpackage

### src/xsr_req_if.sv
// xsr_req_if: request channel (reseed or draw) with valid/ready handshake.
// Depends on xsr_pkg for the payload types.
interface xsr_req_if;
  import xsr_pkg::*;

  logic valid;
  logic ready;
  logic req_type;
  run_t run_index;

  modport source (output valid, output req_type, output run_index, input ready);
  modport sink   (input valid, input req_type, input run_index, output ready);
endinterface

### src/xsr_res_if.sv
// xsr_res_if: result channel carrying the output word and its mantissa bits.
// Depends on xsr_pkg for the payload types.
interface xsr_res_if;
  import xsr_pkg::*;

  logic  valid;
  logic  ready;
  word_t random_word;
  mant_t uniform_bits;

  modport source (output valid, output random_word, output uniform_bits, input ready);
  modport sink   (input valid, input random_word, input uniform_bits, output ready);
endinterface

### src/xoshiro256ss_prng_with_reseed_core.sv
// Draw: accepted when idle, result registered after z gets s1 * 5; one at a time.
// Reseed: a setup, five SplitMix64 mixes and WARMUP_STEPS advances; busy, no result;
//   the 64-bit products go through one 32x32 multiplier, three partial products each.
// The output register lets the next request in while a result waits to be taken.
// Reset (rst_n low, synchronous): idle, no result pending, state words zero,
//   base seed 12345.
module xoshiro256ss_prng_with_reseed_core (
  input  logic           clk,
  input  logic           rst_n,
  xsr_req_if.sink        in_ch,
  xsr_res_if.source      out_ch,
  input  logic           cfg_we,
  input  xsr_pkg::word_t cfg_wdata
);
  import xsr_pkg::*;

  xsr_ctl_t ctl;
  logic     busy;
  logic     in_fire;

  word_t base_r, base_nxt;
  run_t  run_r,  run_nxt;
  word_t z_r,    z_nxt;
  word_t acc_r,  acc_nxt;
  word_t prod_r, prod_nxt;
  word_t ctr_r,  ctr_nxt;
  word_t s_r   [SEED_WORDS];
  word_t s_nxt [SEED_WORDS];
  word_t out_word_r, out_word_nxt;
  logic  out_valid_r, out_valid_nxt;

  logic [31:0] mul_a, mul_b;
  word_t       k_word;
  word_t       adv_t, adv_02, adv_13;
  word_t       rz;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !busy;

  xsr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire),
    .start_draw (in_ch.req_type == REQ_DRAW),
    .out_hold   (out_valid_r && !out_ch.ready),
    .busy       (busy),
    .ctl        (ctl)
  );

  // 32x32 partial product unit
  always_comb begin
    case (ctl.k_sel)
      K_GOLD:  k_word = GOLDEN_INC;
      K_MIXA:  k_word = MIX_MUL_A;
      K_MIXB:  k_word = MIX_MUL_B;
      default: k_word = GOLDEN_INC;
    endcase
    mul_a    = (ctl.mul_op == MUL_HL) ? z_r[63:32] : z_r[31:0];
    mul_b    = (ctl.mul_op == MUL_LH) ? k_word[63:32] : k_word[31:0];
    prod_nxt = mul_a * mul_b;
  end

  assign adv_t  = {s_r[1][46:0], 17'b0};
  assign adv_02 = s_r[2] ^ s_r[0];
  assign adv_13 = s_r[3] ^ s_r[1];
  assign rz     = {z_r[56:0], z_r[63:57]};

  always_comb begin
    base_nxt      = cfg_we ? cfg_wdata : base_r;
    run_nxt       = in_fire ? in_ch.run_index : run_r;
    z_nxt         = z_r;
    acc_nxt       = acc_r;
    ctr_nxt       = ctr_r;
    s_nxt         = s_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;

    case (ctl.z_op)
      Z_NONE:   z_nxt = z_r;
      Z_RUN1:   z_nxt = {1'b0, run_r} + 64'd1;
      Z_CTRINC: z_nxt = ctr_r + GOLDEN_INC;
      Z_XS30:   z_nxt = z_r ^ {30'b0, z_r[63:30]};
      Z_ACC27:  z_nxt = acc_r ^ {27'b0, acc_r[63:27]};
      Z_ACC31:  z_nxt = acc_r ^ {31'b0, acc_r[63:31]};
      Z_S1X5:   z_nxt = s_r[1] + {s_r[1][61:0], 2'b0};
      default:  z_nxt = z_r;
    endcase

    case (ctl.acc_op)
      ACC_NONE: acc_nxt = acc_r;
      ACC_LOAD: acc_nxt = prod_r;
      ACC_ADDH: acc_nxt = acc_r + {prod_r[31:0], 32'b0};
      default:  acc_nxt = acc_r;
    endcase

    case (ctl.ctr_op)
      C_NONE:  ctr_nxt = ctr_r;
      C_BASE:  ctr_nxt = acc_r + base_r;
      C_INC:   ctr_nxt = ctr_r + GOLDEN_INC;
      C_Z:     ctr_nxt = z_r;
      default: ctr_nxt = ctr_r;
    endcase

    if (ctl.shift_s) begin
      for (int i = 0; i < SEED_WORDS - 1; i++) begin
        s_nxt[i] = s_r[i+1];
      end
      s_nxt[SEED_WORDS-1] = z_r;
    end else if (ctl.adv) begin
      s_nxt[0] = s_r[0] ^ adv_13;
      s_nxt[1] = s_r[1] ^ adv_02;
      s_nxt[2] = adv_02 ^ adv_t;
      s_nxt[3] = {adv_13[18:0], adv_13[63:19]};
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.emit) begin
      // rotl(s1 * 5, 7) * 9
      out_word_nxt  = rz + {rz[60:0], 3'b0};
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_SEED_RST;
      s_r         <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r      <= run_nxt;
    z_r        <= z_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    ctr_r      <= ctr_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.random_word  = out_word_r;
  assign out_ch.uniform_bits = out_word_r[63:11];

  // a reseed never produces a result
  a_reseed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.req_type == REQ_RESEED && !out_valid_r |=> !out_valid_r)
    else $error("reseed request produced a result");

  // an accepted draw is followed by a registered result
  a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.req_type == REQ_DRAW |-> ##3 out_valid_r)
    else $error("draw request gave no result in time");

  // a request is worked on alone
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("ready high right after an accepted request");

endmodule

### src/xsr_seq.sv
// xsr_seq: microcode sequencer: step counter, control store, loop counters.
// Depends on xsr_pkg (microword format and program).
module xsr_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             start_draw,
  input  logic             out_hold,
  output logic             busy,
  output xsr_pkg::xsr_ctl_t ctl
);
  import xsr_pkg::*;

  logic [PC_W-1:0]   pc_r,   pc_nxt;
  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [WARM_W-1:0] warm_r, warm_nxt;
  xsr_uw_t           uw;
  logic              stall;
  logic              warm_done;

  assign uw        = uw_rom(pc_r);
  assign warm_done = (warm_r == WARM_W'(WARMUP_STEPS));
  // a new result waits while the previous one is still held
  assign stall     = busy_r && uw.body.emit && out_hold;
  assign busy      = busy_r;

  always_comb begin
    ctl = uw.body;
    if (uw.store) begin
      if (cnt_r == '0) begin
        ctl.ctr_op = C_Z;      // first mix yields the run seed
      end else begin
        ctl.shift_s = 1'b1;
      end
    end
    if (uw.jc == JC_WARM && warm_done) begin
      ctl.adv = 1'b0;
    end
    if (!busy_r || stall) begin
      ctl = '0;
    end
  end

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    warm_nxt = warm_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = start_draw ? A_DRAW : A_RESEED;
        cnt_nxt  = '0;
        warm_nxt = '0;
      end
    end else if (!stall) begin
      if (uw.store) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      case (uw.jc)
        JC_NONE: begin
          if (uw.fin) begin
            busy_nxt = 1'b0;
          end else begin
            pc_nxt = pc_r + PC_W'(1);
          end
        end
        JC_MIX: begin
          if (cnt_r != CNT_W'(SEED_WORDS)) begin
            pc_nxt = uw.jaddr;
          end else begin
            pc_nxt = pc_r + PC_W'(1);
          end
        end
        JC_WARM: begin
          if (warm_done) begin
            busy_nxt = 1'b0;
          end else begin
            warm_nxt = warm_r + WARM_W'(1);
            pc_nxt   = uw.jaddr;
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
      cnt_r  <= '0;
      warm_r <= '0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      warm_r <= warm_nxt;
    end
  end

endmodule

### dv/xsr_checker.sv
// xsr_checker: watches the request, result and seed-write ports of the xoshiro256** core,
// predicts each draw word and compares it with the result channel.
// Depends on xsr_pkg for widths, request codes and the generator constants.
module xsr_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  logic           in_req_type,
  input  xsr_pkg::run_t  in_run_index,
  input  logic           out_valid,
  input  logic           out_ready,
  input  xsr_pkg::word_t out_random_word,
  input  xsr_pkg::mant_t out_uniform_bits,
  input  logic           cfg_we,
  input  xsr_pkg::word_t cfg_wdata,
  output int             fail_count,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import xsr_pkg::*;

  typedef struct {
    word_t word;
    mant_t mant;
  } draw_result_t;

  word_t        seed_reg;
  word_t        gen_s [SEED_WORDS];
  draw_result_t expected_words [$];

  function automatic word_t rotl64(input word_t v, input int unsigned k);
    return (v << k) | (v >> (WORD_W - k));
  endfunction

  function automatic word_t sm_mix(input word_t z);
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  function automatic void advance_state();
    word_t t;
    t = gen_s[1] << 17;
    gen_s[2] ^= gen_s[0];
    gen_s[3] ^= gen_s[1];
    gen_s[1] ^= gen_s[2];
    gen_s[0] ^= gen_s[3];
    gen_s[2] ^= t;
    gen_s[3] = rotl64(gen_s[3], 45);
  endfunction

  function automatic void reseed_state(input run_t run);
    word_t x;
    word_t ctr;
    x = seed_reg + GOLDEN_INC * (word_t'(run) + 64'd1);
    x += GOLDEN_INC;
    ctr = sm_mix(x);
    for (int j = 0; j < SEED_WORDS; j++) begin
      ctr += GOLDEN_INC;
      gen_s[j] = sm_mix(ctr);
    end
    for (int j = 0; j < WARMUP_STEPS; j++) advance_state();
  endfunction

  task automatic note_mismatch(input string field, input word_t exp_v, input word_t got_v);
    if (fail_count < 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin : predict_and_compare
    draw_result_t exp_r;
    word_t w;
    if (!rst_n) begin
      seed_reg = BASE_SEED_RST;
      foreach (gen_s[j]) gen_s[j] = '0;
      expected_words.delete();
    end else begin
      if (cfg_we) seed_reg = cfg_wdata;
      if (in_valid && in_ready) begin
        if (in_req_type == REQ_DRAW) begin
          // output word comes from the state before the step
          w = rotl64(gen_s[1] * 64'd5, 7) * 64'd9;
          exp_r.word = w;
          exp_r.mant = w[WORD_W-1:11];
          expected_words.push_back(exp_r);
          advance_state();
        end else begin
          reseed_state(in_run_index);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result %h / %h", $time, out_random_word,
                     out_uniform_bits);
          fail_count++;
        end else begin
          exp_r = expected_words.pop_front();
          if (out_random_word !== exp_r.word)
            note_mismatch("random_word", exp_r.word, out_random_word);
          if (out_uniform_bits !== exp_r.mant)
            note_mismatch("uniform_bits", word_t'(exp_r.mant), word_t'(out_uniform_bits));
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

### dv/xoshiro256ss_prng_with_reseed_core_tb.sv
// Testbench top for xoshiro256ss_prng_with_reseed_core: clock, reset, request and
// result-side traffic, base seed writes and the verdict.
// Depends on xsr_pkg, xsr_req_if, xsr_res_if and xsr_checker.
module xoshiro256ss_prng_with_reseed_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xsr_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  word_t cfg_wdata;
  int    fail_count;
  int    pending;
  bit    quiet;
  bit    hold_req;
  int    gap_pct;

  xsr_req_if req_ch ();
  xsr_res_if res_ch ();

  xoshiro256ss_prng_with_reseed_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_ch),
    .out_ch   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  xsr_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req_ch.valid),
    .in_ready        (req_ch.ready),
    .in_req_type     (req_ch.req_type),
    .in_run_index    (req_ch.run_index),
    .out_valid       (res_ch.valid),
    .out_ready       (res_ch.ready),
    .out_random_word (res_ch.random_word),
    .out_uniform_bits(res_ch.uniform_bits),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic run_t rand_run();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return run_t'($urandom_range(0, 15));
      default: return run_t'({$urandom(), $urandom()});
    endcase
  endfunction

  // Entered and left at a falling edge; valid stays high on return.
  task automatic offer_request(input logic kind, input run_t run);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.run_index <= run;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Wait out all results, then give a trailing reseed time to finish.
  task automatic drain_requests();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_base_seed(input word_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : timeout
    #1_500_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : sink_side
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long stall so the core backs up and blocks new requests
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        res_ch.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(30, 150)) @(negedge clk);
          end
          1, 2, 3, 4: begin
            res_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clk);
          end
          default: res_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : stimulus
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_DRAW;
    req_ch.run_index = '0;
    quiet            = 1'b0;
    hold_req         = 1'b0;
    gap_pct          = 20;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero state before any reseed, reset base seed
    offer_request(REQ_DRAW, '0);
    offer_request(REQ_DRAW, '1);
    offer_request(REQ_DRAW, rand_run());
    offer_request(REQ_RESEED, '0);
    repeat (3) offer_request(REQ_DRAW, rand_run());
    offer_request(REQ_RESEED, '1);
    repeat (2) offer_request(REQ_DRAW, '1);
    offer_request(REQ_RESEED, rand_run());
    offer_request(REQ_RESEED, rand_run());
    repeat (2) offer_request(REQ_DRAW, rand_run());
    drain_requests();

    write_base_seed('0);
    offer_request(REQ_RESEED, '0);
    repeat (2) offer_request(REQ_DRAW, '0);
    offer_request(REQ_RESEED, '1);
    offer_request(REQ_DRAW, rand_run());
    drain_requests();

    write_base_seed('1);
    offer_request(REQ_RESEED, '0);
    repeat (2) offer_request(REQ_DRAW, rand_run());
    offer_request(REQ_RESEED, rand_run());
    offer_request(REQ_DRAW, rand_run());
    drain_requests();

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: write_base_seed(64'h0000_0000_0000_0001);
        2: write_base_seed(64'h8000_0000_0000_0000);
        default: write_base_seed({$urandom(), $urandom()});
      endcase
      gap_pct = (p == 3) ? 0 : $urandom_range(5, 40);
      for (int i = 0; i < 240; i++) begin
        if (p == 1 && i == 40) hold_req = 1'b1;
        if (p == 2 && i == 120) begin
          req_ch.valid <= 1'b0;
          do @(negedge clk); while (pending != 0);
        end
        if (p == 5 && i == 120) quiet = 1'b1;
        offer_request(($urandom_range(0, 99) < 12) ? REQ_RESEED : REQ_DRAW, rand_run());
      end
      drain_requests();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/xsr_pkg.sv
src/xsr_req_if.sv
src/xsr_res_if.sv
src/xsr_seq.sv
src/xoshiro256ss_prng_with_reseed_core.sv
dv/xsr_checker.sv
dv/xoshiro256ss_prng_with_reseed_core_tb.sv
